@@ hw/rtl/fasta_fastq_sequence_extractor_macros.svh @@
// Assertion macros for the sequence extractor.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef FASTA_FASTQ_SEQUENCE_EXTRACTOR_MACROS_SVH
`define FASTA_FASTQ_SEQUENCE_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FFSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffse assertion failed (same cycle)");

// Next-cycle implication, disabled during reset.
`define FFSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffse assertion failed (next cycle)");

`endif

@@ hw/rtl/ffse_pkg.sv @@
// Package for the sequence extractor: formats, line states, byte constants
// and classification helpers. No dependencies.
package ffse_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int TOTAL_WIDTH = 32;

    typedef enum logic [1:0] {
        FMT_RAW   = 2'd0,
        FMT_FASTA = 2'd1,
        FMT_FASTQ = 2'd2
    } t_format;

    typedef enum logic [1:0] {
        LS_HEADER = 2'd0,
        LS_SEQ    = 2'd1,
        LS_PLUS   = 2'd2,
        LS_QUAL   = 2'd3
    } t_line_state;

    localparam logic [7:0] CH_GT    = 8'h3E; // '>'
    localparam logic [7:0] CH_AT    = 8'h40; // '@'
    localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
    localparam logic [7:0] CH_SPACE = 8'h20; // ' '
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_LG    = 8'h67;
    localparam logic [7:0] CH_UT    = 8'h54;
    localparam logic [7:0] CH_LT    = 8'h74;

    function automatic logic is_base(input logic [7:0] c);
        return (c == CH_UA) || (c == CH_LA) || (c == CH_UC) || (c == CH_LC) ||
               (c == CH_UG) || (c == CH_LG) || (c == CH_UT) || (c == CH_LT);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

@@ hw/rtl/ffse_if.sv @@
// Stream interfaces for the sequence extractor: byte input and result output.
// Depends on ffse_pkg.
interface ffse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_of_file;
    logic       end_of_file;

    modport source (output valid, in_byte, start_of_file, end_of_file, input ready);
    modport sink   (input valid, in_byte, start_of_file, end_of_file, output ready);
endinterface

interface ffse_out_if;
    logic                                valid;
    logic                                ready;
    logic                                kept;
    logic [7:0]                          seq_byte;
    logic [1:0]                          file_format;
    logic [ffse_pkg::TOTAL_WIDTH-1:0]    kept_total;
    logic                                file_end;

    modport source (output valid, kept, seq_byte, file_format, kept_total, file_end,
                    input ready);
    modport sink   (input valid, kept, seq_byte, file_format, kept_total, file_end,
                    output ready);
endinterface

@@ hw/rtl/fasta_fastq_sequence_extractor.sv @@
// Top level of the FASTA / FASTQ / raw sequence byte extractor.
// Depends on ffse_pkg, ffse_if.sv and fasta_fastq_sequence_extractor_macros.svh.
//
// One byte in, one result out, one transfer per cycle sustained while the
// output is taken. A byte is captured in an input register, classified by a
// small line-state machine and written with its result into an output
// register, which offers the result. The pipe stalls only when the output
// register is full and not taken; while it waits, an empty input register
// still takes the next byte. The first byte of a file (start_of_file) picks
// the format ('>' FASTA, '@' FASTQ, anything else raw) and clears the line
// state and the saturating kept count; the byte is then handled as usual.
// Bytes arriving before any start of file are treated as raw; bytes after
// end_of_file without a fresh start continue the current file.
`include "fasta_fastq_sequence_extractor_macros.svh"

module fasta_fastq_sequence_extractor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ffse_in_if.sink           i_in,
    ffse_out_if.source        o_out
);

    localparam logic [ffse_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [63:0] TOTAL_MAX = 64'((65'd1 << ffse_pkg::TOTAL_WIDTH) - 65'd1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_sof;
    logic       r_in_eof;

    // file state
    ffse_pkg::t_format               r_fmt, n_fmt;
    ffse_pkg::t_line_state           r_ls, n_ls;
    logic [ffse_pkg::COUNT_WIDTH-1:0] r_cnt, n_cnt;

    // output register
    logic                             r_out_valid;
    logic                             r_out_kept;
    logic [7:0]                       r_out_byte;
    ffse_pkg::t_format                r_out_fmt;
    logic [ffse_pkg::TOTAL_WIDTH-1:0] r_out_total;
    logic                             r_out_eof;

    logic                             advance;   // output slot free this cycle
    logic                             fire;      // input register moves to output
    ffse_pkg::t_line_state            ls_cur;    // line state after start-of-file clear
    logic [ffse_pkg::COUNT_WIDTH-1:0] cnt_cur;
    logic                             keep;
    logic [63:0]                      cnt_ext;
    logic [ffse_pkg::TOTAL_WIDTH-1:0] total_capped;

    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    // format pick and clears on the first byte of a file
    always_comb begin
        n_fmt   = r_fmt;
        ls_cur  = r_ls;
        cnt_cur = r_cnt;
        if (r_in_sof) begin
            ls_cur  = ffse_pkg::LS_HEADER;
            cnt_cur = '0;
            if (r_in_byte == ffse_pkg::CH_GT) begin
                n_fmt = ffse_pkg::FMT_FASTA;
            end else if (r_in_byte == ffse_pkg::CH_AT) begin
                n_fmt = ffse_pkg::FMT_FASTQ;
            end else begin
                n_fmt = ffse_pkg::FMT_RAW;
            end
        end
    end

    // line state: next-state logic
    always_comb begin
        n_ls = ls_cur;
        case (n_fmt)
            ffse_pkg::FMT_FASTA: begin
                if (r_in_byte == ffse_pkg::CH_GT) begin
                    n_ls = ffse_pkg::LS_HEADER;
                end else if (ffse_pkg::is_eol(r_in_byte)) begin
                    n_ls = ffse_pkg::LS_SEQ;
                end
            end
            ffse_pkg::FMT_FASTQ: begin
                if (r_in_byte == ffse_pkg::CH_AT) begin
                    n_ls = ffse_pkg::LS_HEADER;
                end else if (r_in_byte == ffse_pkg::CH_PLUS &&
                             (ls_cur == ffse_pkg::LS_HEADER ||
                              ls_cur == ffse_pkg::LS_SEQ)) begin
                    n_ls = ffse_pkg::LS_PLUS;
                end else if (ffse_pkg::is_eol(r_in_byte)) begin
                    if (ls_cur == ffse_pkg::LS_HEADER) begin
                        n_ls = ffse_pkg::LS_SEQ;
                    end else if (ls_cur == ffse_pkg::LS_PLUS) begin
                        n_ls = ffse_pkg::LS_QUAL;
                    end
                end
            end
            default: begin
                n_ls = ls_cur;   // raw: line state unused
            end
        endcase
    end

    // line state: output logic (keep decision)
    always_comb begin
        keep = 1'b0;
        case (n_fmt)
            ffse_pkg::FMT_FASTA: begin
                keep = (r_in_byte != ffse_pkg::CH_GT) && !ffse_pkg::is_eol(r_in_byte) &&
                       (ls_cur == ffse_pkg::LS_SEQ) && (r_in_byte != ffse_pkg::CH_SPACE);
            end
            ffse_pkg::FMT_FASTQ: begin
                // '@', '+', CR and LF are never bases, so the base test suffices
                keep = (ls_cur == ffse_pkg::LS_SEQ) && ffse_pkg::is_base(r_in_byte);
            end
            default: begin
                keep = ffse_pkg::is_base(r_in_byte);
            end
        endcase
    end

    // saturating count, shown capped to the output width
    assign n_cnt        = (keep && cnt_cur != COUNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
    assign cnt_ext      = 64'(n_cnt);
    assign total_capped = (cnt_ext > TOTAL_MAX) ? '1 : cnt_ext[ffse_pkg::TOTAL_WIDTH-1:0];

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fmt       <= ffse_pkg::FMT_RAW;
            r_ls        <= ffse_pkg::LS_HEADER;
            r_cnt       <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_fmt <= n_fmt;
                r_ls  <= n_ls;
                r_cnt <= n_cnt;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_sof  <= i_in.start_of_file;
            r_in_eof  <= i_in.end_of_file;
        end
        if (fire) begin
            r_out_kept  <= keep;
            r_out_byte  <= keep ? r_in_byte : 8'd0;
            r_out_fmt   <= n_fmt;
            r_out_total <= total_capped;
            r_out_eof   <= r_in_eof;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kept        = r_out_kept;
    assign o_out.seq_byte    = r_out_byte;
    assign o_out.file_format = r_out_fmt;
    assign o_out.kept_total  = r_out_total;
    assign o_out.file_end    = r_out_eof;

    // a waiting result is never dropped
    `FFSE_ASSERT_NEXT(a_out_held, r_out_valid && !o_out.ready, r_out_valid)
    // within a file the kept count never goes down
    `FFSE_ASSERT_NEXT(a_cnt_mono, fire && !r_in_sof, r_cnt >= $past(r_cnt))
    // a kept byte always shows a non-zero total
    `FFSE_ASSERT_NOW(a_kept_total, r_out_valid && r_out_kept, r_out_total != '0)
    // an input byte is held while the pipe is stalled
    `FFSE_ASSERT_NEXT(a_in_hold, r_in_valid && !advance, r_in_valid && $stable(r_in_byte))

endmodule
